// ----- sv/zcc_pkg.sv -----
// Package for the caseless zero-trim string comparator: codes, character constants and types.
`timescale 1ns / 1ps

package zcc_pkg;

  localparam int MAX_LEN_DEF = 256;

  // Request codes
  localparam logic [1:0] REQ_APPEND_A = 2'd0;
  localparam logic [1:0] REQ_APPEND_B = 2'd1;
  localparam logic [1:0] REQ_COMPARE  = 2'd2;

  // Order codes (two's complement)
  localparam logic signed [1:0] ORDER_LT = -2'sd1;
  localparam logic signed [1:0] ORDER_EQ = 2'sd0;
  localparam logic signed [1:0] ORDER_GT = 2'sd1;

  // Characters
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRAIL_RD,
    ST_TRAIL_CHK,
    ST_LEAD_RD,
    ST_LEAD_CHK,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_DONE
  } state_t;

  // Per-byte classification
  typedef struct packed {
    logic is_space;
    logic is_lead;   // '0' or space
  } byte_cls_t;

  // Folded byte comparison
  typedef struct packed {
    logic eq;
    logic a_lt_b;
  } byte_cmp_t;

endpackage

// ----- sv/zcc_if.sv -----
// Request and result channel interfaces for the comparator.
`timescale 1ns / 1ps

interface zcc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface zcc_res_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] order;
  logic              overflow;

  modport source (output valid, output order, output overflow, input ready);
  modport sink   (input valid, input order, input overflow, output ready);
endinterface

// ----- sv/zcc_strbuf.sv -----
// Single string buffer: one write port, one read port with registered data.
`timescale 1ns / 1ps

module zcc_strbuf #(
  parameter int DEPTH = zcc_pkg::MAX_LEN_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/zcc_fold_cmp.sv -----
// Shared byte unit: classifies both bytes and compares them after upper-case folding.
`timescale 1ns / 1ps

module zcc_fold_cmp (
  input  logic                  [7:0] byte_a,
  input  logic                  [7:0] byte_b,
  output zcc_pkg::byte_cls_t          cls_a,
  output zcc_pkg::byte_cls_t          cls_b,
  output zcc_pkg::byte_cmp_t          cmp
);

  logic [7:0] up_a;
  logic [7:0] up_b;

  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    if (c >= zcc_pkg::CH_LOWER_A && c <= zcc_pkg::CH_LOWER_Z) begin
      return c - zcc_pkg::CASE_OFFSET;
    end
    return c;
  endfunction

  assign up_a = fold_upper(byte_a);
  assign up_b = fold_upper(byte_b);

  assign cls_a.is_space = (byte_a == zcc_pkg::CH_SPACE);
  assign cls_a.is_lead  = (byte_a == zcc_pkg::CH_SPACE) || (byte_a == zcc_pkg::CH_ZERO);
  assign cls_b.is_space = (byte_b == zcc_pkg::CH_SPACE);
  assign cls_b.is_lead  = (byte_b == zcc_pkg::CH_SPACE) || (byte_b == zcc_pkg::CH_ZERO);

  assign cmp.eq     = (up_a == up_b);
  assign cmp.a_lt_b = (up_a < up_b);

endmodule

// ----- sv/zero_trim_caseless_compare.sv -----
// Top level of the caseless zero-trim string comparator.
`timescale 1ns / 1ps

// Collation comparator. Each append transaction (req_type 0 for string A, 1 for
// string B) stores data_byte in that string's buffer; a byte sent to
// a full buffer is dropped and the overflow flag is set. A compare transaction
// (req_type 2) trims both strings - trailing spaces when pad_space is 1, then
// leading '0' and space bytes always - and compares the rest byte by byte with
// a-z folded to upper case; a string that is a prefix of the other sorts first.
// One result transaction comes out per compare, with order -1/0/1 and overflow,
// and both strings and the flag are then cleared. req_type 3 is ignored.
// A compare steps both buffers in parallel through their single read ports,
// each step a read state then a check state in the shared byte unit. No
// request is taken during a compare. The result sits in an output register,
// so appends for the next compare are taken while it waits; a further compare
// finishing before the previous result is taken waits for it. pad_space is
// written through cfg_wr_en and cfg_wr_data; the user must write it only while
// the block is idle, which the block itself does not enforce. No clearing pass
// after reset.

module zero_trim_caseless_compare #(
  parameter int MAX_LEN = zcc_pkg::MAX_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  zcc_req_if.sink         req,
  zcc_res_if.source       res
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  zcc_pkg::state_t state, state_next;

  logic                 pad_space;
  logic [LW-1:0]        len      [2];
  logic [LW-1:0]        len_next [2];
  logic [LW-1:0]        beg      [2];   // first live byte
  logic [LW-1:0]        beg_next [2];
  logic [LW-1:0]        fin      [2];   // one past last live byte
  logic [LW-1:0]        fin_next [2];
  logic [1:0]           sdone, sdone_next;   // per-side scan finished
  logic                 truncated, truncated_next;
  logic signed [1:0]    res_order, res_order_next;

  logic                 out_valid, out_valid_next;
  logic signed [1:0]    out_order, out_order_next;
  logic                 out_ovf, out_ovf_next;

  logic [1:0]           wr_en;
  logic [AW-1:0]        rd_addr [2];
  logic [7:0]           rd_data [2];
  logic [LW-1:0]        fin_m1  [2];
  logic [1:0]           trail_live, lead_live, cmp_more;

  zcc_pkg::byte_cls_t   cls_a, cls_b;
  zcc_pkg::byte_cmp_t   cmp;
  logic [1:0]           is_space, is_lead;
  logic                 accept;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == zcc_pkg::ST_IDLE);

  assign res.valid    = out_valid;
  assign res.order    = out_order;
  assign res.overflow = out_ovf;

  // Buffers: A is side 0, B is side 1
  for (genvar s = 0; s < 2; s++) begin : g_buf
    assign fin_m1[s]  = fin[s] - LW'(1);
    assign rd_addr[s] = (state == zcc_pkg::ST_TRAIL_RD) ? fin_m1[s][AW-1:0] : beg[s][AW-1:0];

    zcc_strbuf #(
      .DEPTH (MAX_LEN),
      .AW    (AW)
    ) u_buf (
      .clk     (clk),
      .wr_en   (wr_en[s]),
      .wr_addr (len[s][AW-1:0]),
      .wr_data (req.data_byte),
      .rd_addr (rd_addr[s]),
      .rd_data (rd_data[s])
    );

    assign trail_live[s] = pad_space && (fin[s] != '0) && !sdone[s];
    assign lead_live[s]  = (beg[s] < fin[s]) && !sdone[s];
    assign cmp_more[s]   = (beg[s] < fin[s]);
  end

  // Shared byte classifier and comparer
  zcc_fold_cmp u_fold_cmp (
    .byte_a (rd_data[0]),
    .byte_b (rd_data[1]),
    .cls_a  (cls_a),
    .cls_b  (cls_b),
    .cmp    (cmp)
  );

  assign is_space = {cls_b.is_space, cls_a.is_space};
  assign is_lead  = {cls_b.is_lead, cls_a.is_lead};

  // Sequencer
  always_comb begin
    state_next     = state;
    len_next       = len;
    beg_next       = beg;
    fin_next       = fin;
    sdone_next     = sdone;
    truncated_next = truncated;
    res_order_next = res_order;
    wr_en          = '0;
    out_valid_next = out_valid && !res.ready;
    out_order_next = out_order;
    out_ovf_next   = out_ovf;

    unique case (state)
      zcc_pkg::ST_IDLE: begin
        if (accept) begin
          priority if (req.req_type == zcc_pkg::REQ_APPEND_A ||
                       req.req_type == zcc_pkg::REQ_APPEND_B) begin
            for (int s = 0; s < 2; s++) begin
              if (req.req_type[0] == s[0]) begin
                if (len[s] < LW'(MAX_LEN)) begin
                  wr_en[s]    = 1'b1;
                  len_next[s] = len[s] + LW'(1);
                end else begin
                  truncated_next = 1'b1;
                end
              end
            end
          end else if (req.req_type == zcc_pkg::REQ_COMPARE) begin
            for (int s = 0; s < 2; s++) begin
              beg_next[s] = '0;
              fin_next[s] = len[s];
            end
            sdone_next = '0;
            state_next = zcc_pkg::ST_TRAIL_RD;
          end else begin
            state_next = zcc_pkg::ST_IDLE;   // unused code
          end
        end
      end

      zcc_pkg::ST_TRAIL_RD: begin
        if (trail_live == '0) begin
          sdone_next = '0;
          state_next = zcc_pkg::ST_LEAD_RD;
        end else begin
          state_next = zcc_pkg::ST_TRAIL_CHK;
        end
      end

      zcc_pkg::ST_TRAIL_CHK: begin
        for (int s = 0; s < 2; s++) begin
          if (trail_live[s]) begin
            if (is_space[s]) begin
              fin_next[s] = fin_m1[s];
            end else begin
              sdone_next[s] = 1'b1;
            end
          end
        end
        state_next = zcc_pkg::ST_TRAIL_RD;
      end

      zcc_pkg::ST_LEAD_RD: begin
        if (lead_live == '0) begin
          state_next = zcc_pkg::ST_CMP_RD;
        end else begin
          state_next = zcc_pkg::ST_LEAD_CHK;
        end
      end

      zcc_pkg::ST_LEAD_CHK: begin
        for (int s = 0; s < 2; s++) begin
          if (lead_live[s]) begin
            if (is_lead[s]) begin
              beg_next[s] = beg[s] + LW'(1);
            end else begin
              sdone_next[s] = 1'b1;
            end
          end
        end
        state_next = zcc_pkg::ST_LEAD_RD;
      end

      zcc_pkg::ST_CMP_RD: begin
        if (cmp_more == 2'b11) begin
          state_next = zcc_pkg::ST_CMP_CHK;
        end else begin
          priority if (cmp_more[0]) begin
            res_order_next = zcc_pkg::ORDER_GT;
          end else if (cmp_more[1]) begin
            res_order_next = zcc_pkg::ORDER_LT;
          end else begin
            res_order_next = zcc_pkg::ORDER_EQ;
          end
          state_next = zcc_pkg::ST_DONE;
        end
      end

      zcc_pkg::ST_CMP_CHK: begin
        if (cmp.eq) begin
          beg_next[0] = beg[0] + LW'(1);
          beg_next[1] = beg[1] + LW'(1);
          state_next  = zcc_pkg::ST_CMP_RD;
        end else begin
          res_order_next = cmp.a_lt_b ? zcc_pkg::ORDER_LT : zcc_pkg::ORDER_GT;
          state_next     = zcc_pkg::ST_DONE;
        end
      end

      zcc_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || res.ready) begin
          out_valid_next = 1'b1;
          out_order_next = res_order;
          out_ovf_next   = truncated;
          len_next[0]    = '0;
          len_next[1]    = '0;
          truncated_next = 1'b0;
          state_next     = zcc_pkg::ST_IDLE;
        end
      end

      default: state_next = zcc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zcc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_space <= 1'b0;
      len[0]    <= '0;
      len[1]    <= '0;
      sdone     <= '0;
      truncated <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pad_space <= cfg_wr_data;
      end
      len       <= len_next;
      sdone     <= sdone_next;
      truncated <= truncated_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    beg       <= beg_next;
    fin       <= fin_next;
    res_order <= res_order_next;
    out_order <= out_order_next;
    out_ovf   <= out_ovf_next;
  end

endmodule

// ----- sv/zcc_checker.sv -----
// Port-level checks for the comparator, bound to the top level.
`timescale 1ns / 1ps

module zcc_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic [1:0]        req_type,
  input logic              res_valid,
  input logic              res_ready,
  input logic signed [1:0] res_order,
  input logic              res_overflow
);

  // A compare drops ready in the cycle after it is taken
  a_compare_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_type == zcc_pkg::REQ_COMPARE) |=> !req_ready)
    else $error("ready still high after compare transaction");

  // Appends and unused codes never block the next transaction
  a_append_ready: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_type != zcc_pkg::REQ_COMPARE) |=> req_ready)
    else $error("ready dropped after non-compare transaction");

  // Only -1, 0 or 1 is ever reported
  a_order_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_order == zcc_pkg::ORDER_LT || res_order == zcc_pkg::ORDER_EQ ||
                   res_order == zcc_pkg::ORDER_GT))
    else $error("illegal order code");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_order) && $stable(res_overflow)))
    else $error("result changed while stalled");

endmodule

bind zero_trim_caseless_compare zcc_checker u_zcc_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_type     (req.req_type),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_order    (res.order),
  .res_overflow (res.overflow)
);
